// ===== rtl/core/tlfs_pkg.sv =====
// Package for the three-level feedback scheduler.
// Holds item kinds, register indexes and shared widths; no dependencies.
package tlfs_pkg;
    localparam int unsigned NUM_LEVELS = 3;
    localparam int unsigned LVL_BITS   = 2;
    localparam int unsigned AGE_BITS   = 16;
    localparam int unsigned PID_W      = 16;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 16;

    typedef enum logic [1:0] {
        KIND_TICK     = 2'd0,
        KIND_ADD      = 2'd1,
        KIND_REMOVE   = 2'd2,
        KIND_DISPATCH = 2'd3
    } t_kind;

    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_QMID      = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_QLOW      = 2'd2;

    localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] proc_id;
        logic [1:0]  level;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_id;
        logic        ok;
        logic        to_completion;
        logic [3:0]  quantum;
        logic        any_left;
        logic        full_res;
    } t_out_item;
endpackage

// ===== rtl/core/tlfs_if.sv =====
// Valid/ready channel interface carrying one payload struct.
// Depends on tlfs_pkg only through the payload type given by the user.
interface tlfs_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/core/three_level_feedback_scheduler.sv =====
// Top level of the three-level feedback scheduler.
// Uses tlfs_pkg, tlfs_if and tlfs_mem.
//
// Three circular FIFO levels of process ids share one slot memory
// (3*SLOTS_PER_LEVEL entries, id and age), with a head pointer and count per
// level in flip-flops. An add writes its slot in ST_EXEC; a dispatch reads
// the head slot in ST_EXEC and rotates or pops it in ST_DSP. Remove walks the
// levels in order, reading one slot at a time, and compacts the rest of the
// level one slot at a time. A tick walks levels 1 and 2 slot by slot, and a
// promotion takes a further compaction walk. One item is worked at a time;
// the result sits in an output register while the next item may be taken.
module three_level_feedback_scheduler #(
    parameter int unsigned SLOTS_PER_LEVEL = 16,
    parameter int unsigned ID_BITS         = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tlfs_if.sink   s_in,
    tlfs_if.source m_out,
    input  logic                              i_cfg_we,
    input  logic [tlfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [tlfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    localparam int unsigned DEPTH  = 3 * SLOTS_PER_LEVEL;
    localparam int unsigned ADDR_W = $clog2(DEPTH);
    localparam int unsigned POS_W  = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
    localparam int unsigned CNT_W  = $clog2(SLOTS_PER_LEVEL + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(SLOTS_PER_LEVEL);
    localparam int unsigned AW     = tlfs_pkg::AGE_BITS;

    typedef enum logic [8:0] {
        ST_IDLE   = 9'b000000001,
        ST_EXEC   = 9'b000000010,
        ST_RD     = 9'b000000100,
        ST_CHK    = 9'b000001000,
        ST_SH_RD  = 9'b000010000,
        ST_SH_WR  = 9'b000100000,
        ST_DSP    = 9'b001000000,
        ST_NEXT   = 9'b010000000,
        ST_OUT    = 9'b100000000
    } t_state;

    // Configuration registers.
    logic [AW-1:0] r_thr;
    logic [3:0]    r_qmid, r_qlow;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr  <= AW'(1000);
            r_qmid <= 4'd4;
            r_qlow <= 4'd1;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                tlfs_pkg::REG_THRESHOLD: r_thr  <= i_cfg_data[AW-1:0];
                tlfs_pkg::REG_QMID:      r_qmid <= i_cfg_data[3:0];
                tlfs_pkg::REG_QLOW:      r_qlow <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    t_state r_st, n_st;
    logic [POS_W-1:0] r_head [3], n_head [3];
    logic [CNT_W-1:0] r_cnt  [3], n_cnt  [3];
    logic [1:0]         r_kind, n_kind;
    logic [ID_BITS-1:0] r_pid, n_pid;
    logic [1:0]         r_lvl, n_lvl;     // level being walked / add target
    logic [CNT_W-1:0]   r_pos, n_pos;     // position within level
    logic [CNT_W-1:0]   r_seen, n_seen;   // entries still to age
    logic               r_shift_tick, n_shift_tick;
    logic [ID_BITS-1:0] r_prom_id, n_prom_id;
    logic [CNT_W-1:0]   r_sh_start;
    tlfs_pkg::t_out_item r_res, n_res;
    tlfs_pkg::t_out_item r_out, n_out;
    logic r_ovalid, n_ovalid;

    // Memory port signals.
    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    logic [ID_BITS-1:0] mem_wid, mem_rid;
    logic [AW-1:0]     mem_wage, mem_rage;

    tlfs_mem #(.DEPTH(DEPTH), .ADDR_W(ADDR_W), .ID_W(ID_BITS), .AGE_W(AW)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wid  (mem_wid),
        .i_wage (mem_wage),
        .i_raddr(mem_raddr),
        .o_rid  (mem_rid),
        .o_rage (mem_rage)
    );

    // Physical address of position p in level l.
    function automatic logic [ADDR_W-1:0] slot_addr(input logic [1:0] l,
            input logic [POS_W-1:0] hd, input logic [CNT_W-1:0] p);
        logic [CNT_W:0] s;
        logic [POS_W-1:0] q;
        s = {1'b0, CNT_W'(hd)} + {1'b0, p};
        if (s >= (CNT_W+1)'(SLOTS_PER_LEVEL)) begin
            s = s - (CNT_W+1)'(SLOTS_PER_LEVEL);
        end
        q = POS_W'(s);
        return ADDR_W'(ADDR_W'(l) * ADDR_W'(SLOTS_PER_LEVEL) + ADDR_W'(q));
    endfunction

    function automatic logic [POS_W-1:0] inc_head(input logic [POS_W-1:0] hd);
        if ({1'b0, hd} == (POS_W+1)'(SLOTS_PER_LEVEL - 1)) begin
            return '0;
        end
        return POS_W'(hd + POS_W'(1));
    endfunction

    logic any_nz;
    assign any_nz = (n_cnt[0] != '0) || (n_cnt[1] != '0) || (n_cnt[2] != '0);
    logic [AW-1:0] aged;
    assign aged = (mem_rage == tlfs_pkg::AGE_MAX) ? mem_rage : AW'(mem_rage + AW'(1));
    logic [1:0] up_lvl;
    assign up_lvl = 2'(r_lvl - 2'd1);

    // Sequencer: one memory access per cycle.
    always_comb begin
        n_st = r_st;
        n_head = r_head;
        n_cnt = r_cnt;
        n_kind = r_kind;
        n_pid = r_pid;
        n_lvl = r_lvl;
        n_pos = r_pos;
        n_seen = r_seen;
        n_shift_tick = r_shift_tick;
        n_prom_id = r_prom_id;
        n_res = r_res;
        n_out = r_out;
        n_ovalid = r_ovalid;
        mem_we = 1'b0;
        mem_waddr = '0;
        mem_wid = '0;
        mem_wage = '0;
        mem_raddr = '0;
        if (m_out.ready) begin
            n_ovalid = 1'b0;
        end
        unique case (r_st)
            ST_IDLE: begin
                if (s_in.valid) begin
                    n_kind = s_in.data.kind;
                    n_pid = ID_BITS'(s_in.data.proc_id);
                    n_lvl = s_in.data.level;
                    n_res = '0;
                    n_st = ST_EXEC;
                end
            end
            ST_EXEC: begin
                n_pos = '0;
                unique case (r_kind)
                    tlfs_pkg::KIND_ADD: begin
                        if (r_lvl != 2'd3) begin
                            if (r_cnt[r_lvl] == FULL_CNT) begin
                                n_res.full_res = 1'b1;
                            end else begin
                                mem_we = 1'b1;
                                mem_waddr = slot_addr(r_lvl, r_head[r_lvl], r_cnt[r_lvl]);
                                mem_wid = r_pid;
                                n_cnt[r_lvl] = CNT_W'(r_cnt[r_lvl] + CNT_W'(1));
                                n_res.ok = 1'b1;
                            end
                        end
                        n_st = ST_OUT;
                    end
                    tlfs_pkg::KIND_DISPATCH: begin
                        if (r_cnt[0] != '0) n_lvl = 2'd0;
                        else if (r_cnt[1] != '0) n_lvl = 2'd1;
                        else n_lvl = 2'd2;
                        if (r_cnt[0] == '0 && r_cnt[1] == '0 && r_cnt[2] == '0) begin
                            n_st = ST_OUT;
                        end else begin
                            mem_raddr = slot_addr(n_lvl, r_head[n_lvl], '0);
                            n_st = ST_DSP;
                        end
                    end
                    tlfs_pkg::KIND_REMOVE: begin
                        n_lvl = 2'd0;
                        n_st = ST_NEXT;
                    end
                    default: begin
                        n_lvl = 2'd1;
                        n_seen = r_cnt[1];
                        n_st = ST_NEXT;
                    end
                endcase
            end
            ST_DSP: begin
                n_res.out_id = 16'(mem_rid);
                n_res.ok = 1'b1;
                n_head[r_lvl] = inc_head(r_head[r_lvl]);
                if (r_lvl == 2'd0) begin
                    n_res.to_completion = 1'b1;
                    n_cnt[0] = CNT_W'(r_cnt[0] - CNT_W'(1));
                end else begin
                    // Rotate: the head entry is written again just past the old tail.
                    mem_we = 1'b1;
                    mem_waddr = slot_addr(r_lvl, r_head[r_lvl], r_cnt[r_lvl]);
                    mem_wid = mem_rid;
                    n_res.quantum = (r_lvl == 2'd1) ? r_qmid : r_qlow;
                end
                n_st = ST_OUT;
            end
            ST_NEXT: begin
                // Start or continue a walk over the current level.
                if (r_kind == tlfs_pkg::KIND_REMOVE) begin
                    if (r_pos < r_cnt[r_lvl]) begin
                        mem_raddr = slot_addr(r_lvl, r_head[r_lvl], r_pos);
                        n_st = ST_CHK;
                    end else if (r_lvl == 2'd2) begin
                        n_st = ST_OUT;
                    end else begin
                        n_lvl = 2'(r_lvl + 2'd1);
                        n_pos = '0;
                    end
                end else begin
                    if (r_seen != '0) begin
                        mem_raddr = slot_addr(r_lvl, r_head[r_lvl], r_pos);
                        n_st = ST_CHK;
                    end else if (r_lvl == 2'd2) begin
                        n_st = ST_OUT;
                    end else begin
                        n_lvl = 2'd2;
                        n_pos = '0;
                        n_seen = r_cnt[2];
                    end
                end
            end
            ST_CHK: begin
                if (r_kind == tlfs_pkg::KIND_REMOVE) begin
                    if (mem_rid == r_pid) begin
                        n_res.ok = 1'b1;
                        n_shift_tick = 1'b0;
                        n_st = ST_SH_RD;
                    end else begin
                        n_pos = CNT_W'(r_pos + CNT_W'(1));
                        n_st = ST_NEXT;
                    end
                end else begin
                    n_seen = CNT_W'(r_seen - CNT_W'(1));
                    if (aged >= r_thr && r_cnt[up_lvl] != FULL_CNT) begin
                        n_prom_id = mem_rid;
                        n_shift_tick = 1'b1;
                        n_st = ST_SH_RD;
                    end else begin
                        mem_we = 1'b1;
                        mem_waddr = slot_addr(r_lvl, r_head[r_lvl], r_pos);
                        mem_wid = mem_rid;
                        mem_wage = aged;
                        n_pos = CNT_W'(r_pos + CNT_W'(1));
                        n_st = ST_NEXT;
                    end
                end
            end
            ST_SH_RD: begin
                // Compact: move entry pos+1 down to pos, or finish the drop and append any promoted id one level up.
                if (CNT_W'(r_pos + CNT_W'(1)) < r_cnt[r_lvl]) begin
                    mem_raddr = slot_addr(r_lvl, r_head[r_lvl], CNT_W'(r_pos + CNT_W'(1)));
                    n_st = ST_SH_WR;
                end else begin
                    n_cnt[r_lvl] = CNT_W'(r_cnt[r_lvl] - CNT_W'(1));
                    if (r_shift_tick) begin
                        mem_we = 1'b1;
                        mem_waddr = slot_addr(up_lvl, r_head[up_lvl], r_cnt[up_lvl]);
                        mem_wid = r_prom_id;
                        n_cnt[up_lvl] = CNT_W'(r_cnt[up_lvl] + CNT_W'(1));
                        n_pos = r_sh_start;
                        n_st = ST_NEXT;
                    end else begin
                        n_st = ST_OUT;
                    end
                end
            end
            ST_SH_WR: begin
                mem_we = 1'b1;
                mem_waddr = slot_addr(r_lvl, r_head[r_lvl], r_pos);
                mem_wid = mem_rid;
                mem_wage = mem_rage;
                n_pos = CNT_W'(r_pos + CNT_W'(1));
                n_st = ST_SH_RD;
            end
            ST_OUT: begin
                if (!r_ovalid || m_out.ready) begin
                    n_out = r_res;
                    n_out.any_left = any_nz;
                    n_ovalid = 1'b1;
                    n_st = ST_IDLE;
                end
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // Resume position after a promotion: the walk continues at the slot
    // where the promoted entry was.
    always_ff @(posedge i_clk) begin
        if (r_st == ST_CHK) begin
            r_sh_start <= r_pos;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < 3; i++) begin
                r_head[i] <= '0;
                r_cnt[i] <= '0;
            end
            r_shift_tick <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ovalid <= n_ovalid;
            r_head <= n_head;
            r_cnt <= n_cnt;
            r_shift_tick <= n_shift_tick;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_pid <= n_pid;
        r_lvl <= n_lvl;
        r_pos <= n_pos;
        r_seen <= n_seen;
        r_prom_id <= n_prom_id;
        r_res <= n_res;
        r_out <= n_out;
    end

    assign s_in.ready = (r_st == ST_IDLE);
    assign m_out.valid = r_ovalid;
    assign m_out.data = r_out;
endmodule

// ===== rtl/core/tlfs_mem.sv =====
// Synchronous slot memory: id and age per slot, one write and one read port.
// Read data registered; no dependencies.
module tlfs_mem #(
    parameter int unsigned DEPTH  = 48,
    parameter int unsigned ADDR_W = 6,
    parameter int unsigned ID_W   = 16,
    parameter int unsigned AGE_W  = 16
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [ID_W-1:0]   i_wid,
    input  logic [AGE_W-1:0]  i_wage,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [ID_W-1:0]   o_rid,
    output logic [AGE_W-1:0]  o_rage
);
    logic [ID_W+AGE_W-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= {i_wid, i_wage};
        end
        {o_rid, o_rage} <= r_mem[i_raddr];
    end
endmodule

// ===== rtl/core/tlfs_checker.sv =====
// Port-level checker for the three-level feedback scheduler, with its bind.
// Depends on tlfs_pkg for the payload layout.
module tlfs_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input tlfs_pkg::t_out_item out_data
);
    // A stalled result holds its value.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    // Run to completion never comes with a quantum.
    a_tc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.to_completion |-> out_data.quantum == 4'd0 && out_data.ok)
        else $error("run to completion with quantum");

    // A dropped add is never ok.
    a_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_data.full_res |-> !out_data.ok)
        else $error("full add reported ok");

    // No transaction is taken in the cycle right after one.
    a_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken too early");
endmodule

bind three_level_feedback_scheduler tlfs_checker u_tlfs_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (s_in.valid),
    .in_ready (s_in.ready),
    .out_valid(m_out.valid),
    .out_ready(m_out.ready),
    .out_data (m_out.data)
);
